@@ rtl/fits_column_type_converter_macros.svh @@
// Assertion macros for the column type converter.
// Expects i_clk and i_rst_n in the scope of the module that uses them.
`ifndef FITS_COLUMN_TYPE_CONVERTER_MACROS_SVH
`define FITS_COLUMN_TYPE_CONVERTER_MACROS_SVH

// Same-cycle implication, off while reset is held.
`define FCC_CHECK(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("fcc: same-cycle check failed");

// Next-cycle implication, off while reset is held.
`define FCC_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("fcc: next-cycle check failed");

// Signal must be low in the cycle after reset is applied.
`define FCC_RESET_LOW(lbl, sig) \
    lbl: assert property (@(posedge i_clk) !i_rst_n |=> !(sig)) \
        else $error("fcc: signal not cleared by reset");

`endif

@@ rtl/fcc_pkg.sv @@
// Shared types and constants for the column type converter.
// No dependencies.
`timescale 1ns / 1ps

package fcc_pkg;

    // column type codes
    localparam logic [3:0] TY_CHAR    = 4'd0;
    localparam logic [3:0] TY_BITS    = 4'd1;
    localparam logic [3:0] TY_BYTE    = 4'd2;
    localparam logic [3:0] TY_LOGICAL = 4'd3;
    localparam logic [3:0] TY_I16     = 4'd4;
    localparam logic [3:0] TY_I32     = 4'd5;
    localparam logic [3:0] TY_I64     = 4'd6;
    localparam logic [3:0] TY_SINGLE  = 4'd7;
    localparam logic [3:0] TY_DOUBLE  = 4'd8;

    // status codes
    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_BAD_TYPE   = 2'd1;
    localparam logic [1:0] ST_SATURATED  = 2'd2;
    localparam logic [1:0] ST_NAN_TO_INT = 2'd3;

    // register indexes
    localparam logic CFG_SOURCE_TYPE = 1'b0;
    localparam logic CFG_DEST_TYPE   = 1'b1;

    localparam logic [3:0] TYPE_RESET = TY_BYTE;

    localparam logic [7:0] LOGICAL_TRUE  = 8'h54;
    localparam logic [7:0] LOGICAL_FALSE = 8'h46;

    typedef struct packed {
        logic [63:0] raw_value;
        logic        last_element;
    } t_in_beat;

    typedef struct packed {
        logic [63:0] result_bits;
        logic        result_last;
        logic [1:0]  status;
    } t_out_beat;

    // significand cut for rounding: q holds the kept bits with hidden bit,
    // ebase is the biased exponent minus one (zero for subnormals)
    typedef struct packed {
        logic        neg;
        logic        sgl;
        logic [10:0] ebase;
        logic [52:0] q;
        logic        guard;
        logic        sticky;
    } t_rnd_in;

endpackage

@@ rtl/fcc_round.sv @@
// Round-to-nearest-even and pack into IEEE single or double.
// Depends on fcc_pkg.
`timescale 1ns / 1ps

module fcc_round (
    input  fcc_pkg::t_rnd_in i_rnd,
    output logic [63:0]      o_bits
);
    import fcc_pkg::*;

    logic        inc;
    logic [53:0] qr;
    logic [33:0] pk_s;
    logic [63:0] pk_d;

    always_comb begin
        inc  = i_rnd.guard & (i_rnd.sticky | i_rnd.q[0]);
        qr   = {1'b0, i_rnd.q} + {53'd0, inc};
        // hidden bit carries into the exponent, rounding overflow carries twice
        pk_s = {i_rnd.ebase, 23'd0} + {9'd0, qr[24:0]};
        pk_d = {1'b0, i_rnd.ebase, 52'd0} + {10'd0, qr};
        if (i_rnd.sgl) begin
            if (pk_s[33:23] >= 11'd255) begin
                o_bits = {32'd0, i_rnd.neg, 8'hFF, 23'd0};
            end else begin
                o_bits = {32'd0, i_rnd.neg, pk_s[30:0]};
            end
        end else begin
            if (pk_d[63:52] >= 12'd2047) begin
                o_bits = {i_rnd.neg, 11'h7FF, 52'd0};
            end else begin
                o_bits = {i_rnd.neg, pk_d[62:0]};
            end
        end
    end

endmodule

@@ rtl/fits_column_type_converter.sv @@
// Column type converter: one table element in, one converted element out per cycle when not stalled.
// Depends on fcc_pkg, fcc_round and fits_column_type_converter_macros.svh.
//
// Takes one beat per clock and returns one beat per clock when not stalled.
// The work runs through six register stages (source decode, magnitude,
// leading-zero count, normalize shift, rounding cut with truncation shift,
// round/saturate/pack into the output register), all advancing together;
// i_stall from the sink holds the whole pipe and comes straight back out as
// o_stall while the output register is full. Source and destination types
// are sampled when a beat enters, so write them only with the pipe empty. A
// type code above 8 gives status 1 with zero bits.
`timescale 1ns / 1ps
`include "fits_column_type_converter_macros.svh"

module fits_column_type_converter (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_cfg_idx,
    input  logic [3:0]         i_cfg_data,
    input  logic               i_valid,
    output logic               o_stall,
    input  fcc_pkg::t_in_beat  i_data,
    output logic               o_valid,
    input  logic               i_stall,
    output fcc_pkg::t_out_beat o_data
);
    import fcc_pkg::*;

    typedef enum logic [1:0] {FC_ZERO, FC_FIN, FC_INF, FC_NAN} t_fcls;

    typedef struct packed {
        logic [3:0]         src;
        logic [3:0]         dst;
        logic               last;
        logic               bad;
        logic               is_int;
        logic               sgl;
        logic               neg;
        t_fcls              fcls;
        logic [63:0]        ival;   // integer value, or raw bits of a double
        logic [10:0]        fexp;
        logic [51:0]        frac;   // fraction aligned to double layout
        logic [63:0]        mag;
        logic signed [12:0] top;
        logic [6:0]         lz;
        logic [63:0]        tint;
        logic               big;
        t_rnd_in            rnd;
    } t_pipe;

    typedef struct packed {
        logic [1:0]  st;
        logic [63:0] bits;
    } t_ires;

    function automatic logic [6:0] f_lzc(input logic [63:0] v);
        logic [6:0] n;
        n = 7'd64;
        for (int i = 0; i < 64; i++) begin
            if (v[i]) n = 7'(63 - i);
        end
        return n;
    endfunction

    // float to signed integer of width w, truncated, saturating
    function automatic t_ires f_to_sint(input logic [63:0] t, input logic big,
                                        input logic neg, input int w);
        logic [63:0] lim;
        logic [63:0] mask;
        t_ires       r;
        lim  = 64'd1 << (w - 1);
        mask = (w >= 64) ? '1 : ((64'd1 << w) - 64'd1);
        r.st = ST_OK;
        if (!neg) begin
            if (big || t > lim - 64'd1) begin
                r.st   = ST_SATURATED;
                r.bits = (lim - 64'd1) & mask;
            end else begin
                r.bits = t & mask;
            end
        end else begin
            if (big || t > lim) begin
                r.st   = ST_SATURATED;
                r.bits = (64'd0 - lim) & mask;
            end else begin
                r.bits = (64'd0 - t) & mask;
            end
        end
        return r;
    endfunction

    logic [3:0]  r_src_type, r_dst_type;
    t_pipe       r_a, r_b, r_c, r_d, r_e;
    t_pipe       n_a, n_b, n_c, n_d, n_e;
    logic [4:0]  r_vld;
    logic        r_out_vld;
    t_out_beat   r_out, n_out;
    logic        en;
    logic [63:0] rnd_bits;
    t_ires       ires;

    // advance whenever the output register is free or being drained
    assign en      = !r_out_vld || !i_stall;
    assign o_stall = !en;
    assign o_valid = r_out_vld;
    assign o_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_type <= TYPE_RESET;
            r_dst_type <= TYPE_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SOURCE_TYPE: r_src_type <= i_cfg_data;
                CFG_DEST_TYPE:   r_dst_type <= i_cfg_data;
                default:         r_src_type <= r_src_type;
            endcase
        end
    end

    // decode the source encoding
    always_comb begin
        n_a        = '0;
        n_a.src    = r_src_type;
        n_a.dst    = r_dst_type;
        n_a.last   = i_data.last_element;
        n_a.bad    = (r_src_type > TY_DOUBLE) || (r_dst_type > TY_DOUBLE);
        n_a.is_int = 1'b1;
        n_a.sgl    = (r_src_type == TY_SINGLE);
        case (r_src_type)
            TY_LOGICAL: n_a.ival = {63'd0, i_data.raw_value[7:0] == LOGICAL_TRUE};
            TY_I16:     n_a.ival = {{48{i_data.raw_value[15]}}, i_data.raw_value[15:0]};
            TY_I32:     n_a.ival = {{32{i_data.raw_value[31]}}, i_data.raw_value[31:0]};
            TY_I64:     n_a.ival = i_data.raw_value;
            TY_SINGLE: begin
                n_a.is_int = 1'b0;
                n_a.neg    = i_data.raw_value[31];
                n_a.fexp   = {3'd0, i_data.raw_value[30:23]};
                n_a.frac   = {i_data.raw_value[22:0], 29'd0};
            end
            TY_DOUBLE: begin
                n_a.is_int = 1'b0;
                n_a.ival   = i_data.raw_value;
                n_a.neg    = i_data.raw_value[63];
                n_a.fexp   = i_data.raw_value[62:52];
                n_a.frac   = i_data.raw_value[51:0];
            end
            default:    n_a.ival = {56'd0, i_data.raw_value[7:0]};
        endcase
        if (!n_a.is_int) begin
            if ((n_a.sgl && n_a.fexp == 11'h0FF) || (!n_a.sgl && n_a.fexp == 11'h7FF)) begin
                n_a.fcls = (n_a.frac != '0) ? FC_NAN : FC_INF;
            end else begin
                n_a.fcls = (n_a.fexp == '0 && n_a.frac == '0) ? FC_ZERO : FC_FIN;
            end
        end
    end

    // magnitude and exponent of the leading bit before normalization
    always_comb begin
        n_b = r_a;
        if (r_a.is_int) begin
            n_b.neg  = r_a.ival[63];
            n_b.mag  = r_a.ival[63] ? (64'd0 - r_a.ival) : r_a.ival;
            n_b.fcls = (r_a.ival == '0) ? FC_ZERO : FC_FIN;
            n_b.top  = 13'sd63;
        end else if (r_a.fexp == '0) begin
            n_b.mag = {r_a.frac, 12'd0};
            n_b.top = r_a.sgl ? -13'sd127 : -13'sd1023;
        end else begin
            n_b.mag = {1'b1, r_a.frac, 11'd0};
            n_b.top = $signed({2'b00, r_a.fexp}) - (r_a.sgl ? 13'sd127 : 13'sd1023);
        end
    end

    always_comb begin
        n_c     = r_b;
        n_c.lz  = f_lzc(r_b.mag);
        n_c.top = r_b.top - $signed({6'd0, n_c.lz});
    end

    always_comb begin
        n_d     = r_c;
        n_d.mag = r_c.mag << r_c.lz[5:0];
    end

    // truncated integer and rounding cut
    always_comb begin
        logic signed [12:0] min_e;
        logic signed [12:0] bias;
        logic signed [12:0] diff;
        logic [6:0]         d;
        logic [127:0]       ext;
        n_e      = r_d;
        n_e.big  = (r_d.fcls == FC_INF) || (r_d.top >= 13'sd63);
        n_e.tint = (r_d.top < 13'sd0 || r_d.top >= 13'sd63) ? 64'd0
                 : (r_d.mag >> (6'd63 - r_d.top[5:0]));
        n_e.rnd.sgl = (r_d.dst == TY_SINGLE);
        n_e.rnd.neg = r_d.neg;
        min_e = n_e.rnd.sgl ? -13'sd126 : -13'sd1022;
        bias  = n_e.rnd.sgl ? 13'sd127 : 13'sd1023;
        diff  = min_e - r_d.top;
        if (diff > 13'sd0) begin
            d             = (diff > 13'sd127) ? 7'd127 : diff[6:0];
            n_e.rnd.ebase = '0;
        end else begin
            d             = '0;
            n_e.rnd.ebase = 11'(r_d.top + bias - 13'sd1);
        end
        ext = {r_d.mag, 64'd0} >> d;
        if (n_e.rnd.sgl) begin
            n_e.rnd.q      = {29'd0, ext[127:104]};
            n_e.rnd.guard  = ext[103];
            n_e.rnd.sticky = |ext[102:0];
        end else begin
            n_e.rnd.q      = ext[127:75];
            n_e.rnd.guard  = ext[74];
            n_e.rnd.sticky = |ext[73:0];
        end
    end

    fcc_round u_round (
        .i_rnd  (r_e.rnd),
        .o_bits (rnd_bits)
    );

    // pick the destination encoding, saturate and flag
    always_comb begin
        n_out.result_last = r_e.last;
        n_out.status      = ST_OK;
        n_out.result_bits = '0;
        ires              = '0;
        case (r_e.dst)
            TY_I16:  ires = f_to_sint(r_e.tint, r_e.big, r_e.neg, 16);
            TY_I32:  ires = f_to_sint(r_e.tint, r_e.big, r_e.neg, 32);
            TY_I64:  ires = f_to_sint(r_e.tint, r_e.big, r_e.neg, 64);
            default: begin
                if (r_e.neg) begin
                    ires.bits = '0;
                    ires.st   = (r_e.big || r_e.tint != '0) ? ST_SATURATED : ST_OK;
                end else if (r_e.big || r_e.tint > 64'd255) begin
                    ires.bits = 64'd255;
                    ires.st   = ST_SATURATED;
                end else begin
                    ires.bits = r_e.tint;
                    ires.st   = ST_OK;
                end
            end
        endcase
        if (r_e.bad) begin
            n_out.status = ST_BAD_TYPE;
        end else begin
            case (r_e.dst)
                TY_LOGICAL: begin
                    n_out.result_bits[7:0] = (r_e.fcls != FC_ZERO) ? LOGICAL_TRUE : LOGICAL_FALSE;
                end
                TY_SINGLE: begin
                    case (r_e.fcls)
                        FC_ZERO: n_out.result_bits = {32'd0, r_e.neg, 31'd0};
                        FC_INF:  n_out.result_bits = {32'd0, r_e.neg, 8'hFF, 23'd0};
                        FC_NAN:  n_out.result_bits = {32'd0, r_e.neg, 9'h1FF, r_e.frac[50:29]};
                        default: n_out.result_bits = rnd_bits;
                    endcase
                end
                TY_DOUBLE: begin
                    if (r_e.is_int || !r_e.sgl) begin
                        n_out.result_bits = r_e.is_int ? rnd_bits : r_e.ival;
                        if (r_e.is_int && r_e.fcls == FC_ZERO) n_out.result_bits = '0;
                    end else begin
                        case (r_e.fcls)
                            FC_ZERO: n_out.result_bits = {r_e.neg, 63'd0};
                            FC_INF:  n_out.result_bits = {r_e.neg, 11'h7FF, 52'd0};
                            FC_NAN:  n_out.result_bits = {r_e.neg, 12'hFFF, r_e.frac[50:0]};
                            default: n_out.result_bits = rnd_bits;
                        endcase
                    end
                end
                default: begin
                    if (r_e.is_int) begin
                        case (r_e.dst)
                            TY_I16:  n_out.result_bits = {48'd0, r_e.ival[15:0]};
                            TY_I32:  n_out.result_bits = {32'd0, r_e.ival[31:0]};
                            TY_I64:  n_out.result_bits = r_e.ival;
                            default: n_out.result_bits = {56'd0, r_e.ival[7:0]};
                        endcase
                    end else if (r_e.fcls == FC_NAN) begin
                        n_out.status = ST_NAN_TO_INT;
                    end else begin
                        n_out.result_bits = ires.bits;
                        n_out.status      = ires.st;
                    end
                end
            endcase
        end
    end

    // payload stages: hold on stall, advance otherwise
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a   <= n_a;
            r_b   <= n_b;
            r_c   <= n_c;
            r_d   <= n_d;
            r_e   <= n_e;
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_vld     <= {r_vld[3:0], i_valid};
            r_out_vld <= r_vld[4];
        end
    end

    `FCC_CHECK(a_bad_type_zero, o_valid && o_data.status == ST_BAD_TYPE, o_data.result_bits == '0)
    `FCC_CHECK(a_nan_int_zero, o_valid && o_data.status == ST_NAN_TO_INT, o_data.result_bits == '0)
    `FCC_NEXT(a_stage_advance, en && r_vld[0], r_vld[1])
    `FCC_NEXT(a_out_load, en && r_vld[4], o_valid)
    `FCC_RESET_LOW(a_reset_empty, o_valid)

endmodule
